>>> rtl/core/psfp_pkg.sv
package psfp_pkg;

    // Storage and counter sizing
    localparam int DEF_BUFFER_BYTES = 40;
    localparam int CNT_W            = 6;

    localparam logic [15:0]      START_WORD       = 16'h424D;
    localparam logic [CNT_W-1:0] HEAD_BYTES       = 6'd4;
    localparam logic [15:0]      WAIT_LIMIT_RESET = 16'd1000;

    // Command codes
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_TRIGGER = 2'd2;

    // Status codes
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_TIMEOUT     = 3'd1;
    localparam logic [2:0] STAT_SHORT_HEAD  = 3'd2;
    localparam logic [2:0] STAT_BAD_START   = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN_LEN = 3'd4;
    localparam logic [2:0] STAT_TOO_LONG    = 3'd5;
    localparam logic [2:0] STAT_SHORT_BODY  = 3'd6;
    localparam logic [2:0] STAT_CHECKSUM    = 3'd7;

    // Frame size classes
    localparam logic [1:0] CLASS_24 = 2'd0;
    localparam logic [1:0] CLASS_32 = 2'd1;
    localparam logic [1:0] CLASS_40 = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  frame_type;
        logic [4:0]  word_index;
        logic [15:0] word_value;
        logic        last;
    } res_item_t;

    typedef struct packed {
        logic      push;
        res_item_t item;
    } res_push_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } outq_stat_t;

    function automatic logic [CNT_W-1:0] frame_bytes(input logic [1:0] cls);
        logic [CNT_W-1:0] n;
        unique case (cls)
            CLASS_24: n = 6'd24;
            CLASS_32: n = 6'd32;
            default:  n = 6'd40;
        endcase
        return n;
    endfunction

    // Index of the final data word in a frame of the given class
    function automatic logic [4:0] last_word(input logic [1:0] cls);
        logic [4:0] n;
        unique case (cls)
            CLASS_24: n = 5'd8;
            CLASS_32: n = 5'd12;
            default:  n = 5'd16;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/psfp_chan_if.sv
interface psfp_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/psfp_ram.sv
module psfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = psfp_pkg::DEF_BUFFER_BYTES,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> rtl/core/psfp_outq.sv
module psfp_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psfp_pkg::res_push_t    q_push,
    output psfp_pkg::outq_stat_t   q_stat,
    psfp_chan_if.source            res
);

    psfp_pkg::res_item_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                pop;

    assign res.valid = (count_reg != 2'd0);
    assign res.data  = entry_reg[rd_ptr_reg];
    assign pop       = res.valid && res.ready;

    assign q_stat.count = count_reg;
    assign q_stat.pop   = pop;

    always_comb
    begin
        wr_ptr_next = q_push.push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, q_push.push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.item;
        end
    end

    // The controller's credit check must never overfill the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.push |-> (count_reg != 2'd2))
        else $error("result queue overflow");

endmodule

>>> rtl/core/psfp_ctrl.sv
module psfp_ctrl #(
    parameter int BUFFER_BYTES = psfp_pkg::DEF_BUFFER_BYTES,
    localparam int AW          = $clog2(BUFFER_BYTES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    psfp_chan_if.sink             cmd,
    psfp_chan_if.sink             cfg,
    output logic                  ram_wr_en,
    output logic [AW-1:0]         ram_wr_addr,
    output logic [7:0]            ram_wr_data,
    output logic                  ram_rd_en,
    output logic [AW-1:0]         ram_rd_addr_a,
    output logic [AW-1:0]         ram_rd_addr_b,
    input  logic [7:0]            ram_rd_data_a,
    input  logic [7:0]            ram_rd_data_b,
    input  psfp_pkg::outq_stat_t  q_stat,
    output psfp_pkg::res_push_t   q_push
);

    typedef enum logic [1:0] {ST_IDLE, ST_HEAD, ST_BODY, ST_EMIT} state_t;

    localparam int CW = psfp_pkg::CNT_W;

    state_t          state_reg,     state_next;
    logic [CW-1:0]   count_reg,     count_next;
    logic [23:0]     hdr_reg,       hdr_next;
    logic [7:0]      prev_byte_reg, prev_byte_next;
    logic [15:0]     sum_reg,       sum_next;
    logic [15:0]     wait_reg,      wait_next;
    logic [1:0]      class_reg,     class_next;
    logic [15:0]     limit_reg,     limit_next;
    logic [4:0]      word_reg,      word_next;
    logic [CW-1:0]   rd_ptr_reg,    rd_ptr_next;
    logic            pend_reg,      pend_next;
    logic [4:0]      pend_idx_reg,  pend_idx_next;
    logic            pend_last_reg, pend_last_next;

    logic            accept;
    logic [1:0]      command;
    logic [7:0]      rx_byte;
    logic [CW-1:0]   msg_bytes;
    logic [15:0]     wait_inc;
    logic [15:0]     hdr_len;
    logic [16:0]     hdr_total;
    logic [15:0]     sum_add;
    logic [CW-1:0]   rd_ptr_b;
    logic [2:0]      occ_next;
    logic            st_push;
    logic [2:0]      st_code;
    logic [1:0]      st_ft;
    logic            hdr_known;
    logic [1:0]      hdr_class;

    assign command   = cmd.data.command;
    assign rx_byte   = cmd.data.rx_byte;
    assign cmd.ready = (state_reg != ST_EMIT) && !pend_reg && (q_stat.count != 2'd2);
    assign cfg.ready = 1'b1;
    assign accept    = cmd.valid && cmd.ready;

    assign msg_bytes = psfp_pkg::frame_bytes(class_reg);
    assign wait_inc  = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
    assign hdr_len   = {hdr_reg[7:0], rx_byte};
    assign hdr_total = {1'b0, hdr_len} + 17'd4;
    assign sum_add   = sum_reg + {8'd0, rx_byte};
    assign rd_ptr_b  = rd_ptr_reg + 6'd1;

    // Queue occupancy after this cycle's push and pop; a read issued now lands next cycle
    assign occ_next  = {1'b0, q_stat.count} + {2'd0, pend_reg} - {2'd0, q_stat.pop};

    always_comb
    begin
        hdr_known = 1'b1;
        hdr_class = psfp_pkg::CLASS_24;
        if (hdr_total == 17'd24)
        begin
            hdr_class = psfp_pkg::CLASS_24;
        end
        else if (hdr_total == 17'd32)
        begin
            hdr_class = psfp_pkg::CLASS_32;
        end
        else if (hdr_total == 17'd40)
        begin
            hdr_class = psfp_pkg::CLASS_40;
        end
        else
        begin
            hdr_known = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        hdr_next       = hdr_reg;
        prev_byte_next = prev_byte_reg;
        sum_next       = sum_reg;
        wait_next      = wait_reg;
        class_next     = class_reg;
        limit_next     = cfg.valid ? cfg.data : limit_reg;
        word_next      = word_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        st_push        = 1'b0;
        st_code        = psfp_pkg::STAT_OK;
        st_ft          = '0;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;

        if (accept && command == psfp_pkg::CMD_TRIGGER)
        begin
            state_next = ST_HEAD;
            count_next = '0;
            sum_next   = '0;
            wait_next  = '0;
            class_next = psfp_pkg::CLASS_24;
        end
        else if (accept && command == psfp_pkg::CMD_TICK
                 && (state_reg == ST_HEAD || state_reg == ST_BODY))
        begin
            wait_next = wait_inc;
            if (wait_inc >= limit_reg)
            begin
                st_push    = 1'b1;
                state_next = ST_IDLE;
                if (state_reg == ST_HEAD)
                begin
                    st_code = (count_reg == '0) ? psfp_pkg::STAT_TIMEOUT
                                                : psfp_pkg::STAT_SHORT_HEAD;
                end
                else
                begin
                    st_code = (count_reg <= psfp_pkg::HEAD_BYTES) ? psfp_pkg::STAT_TIMEOUT
                                                                 : psfp_pkg::STAT_SHORT_BODY;
                    st_ft   = class_reg;
                end
            end
        end
        else if (accept && command == psfp_pkg::CMD_BYTE && state_reg == ST_HEAD)
        begin
            hdr_next   = {hdr_reg[15:0], rx_byte};
            sum_next   = sum_add;
            count_next = count_reg + 6'd1;
            if (count_reg == psfp_pkg::HEAD_BYTES - 6'd1)
            begin
                if (hdr_reg[23:8] != psfp_pkg::START_WORD)
                begin
                    st_push    = 1'b1;
                    st_code    = psfp_pkg::STAT_BAD_START;
                    state_next = ST_IDLE;
                end
                else if (!hdr_known)
                begin
                    st_push    = 1'b1;
                    st_code    = psfp_pkg::STAT_UNKNOWN_LEN;
                    state_next = ST_IDLE;
                end
                else if (int'(psfp_pkg::frame_bytes(hdr_class)) > BUFFER_BYTES)
                begin
                    st_push    = 1'b1;
                    st_code    = psfp_pkg::STAT_TOO_LONG;
                    state_next = ST_IDLE;
                end
                else
                begin
                    class_next = hdr_class;
                    state_next = ST_BODY;
                end
            end
        end
        else if (accept && command == psfp_pkg::CMD_BYTE && state_reg == ST_BODY)
        begin
            ram_wr_en      = 1'b1;
            prev_byte_next = rx_byte;
            count_next     = count_reg + 6'd1;
            if (count_reg < msg_bytes - 6'd2)
            begin
                sum_next = sum_add;
            end
            if (count_reg == msg_bytes - 6'd1)
            begin
                if ({prev_byte_reg, rx_byte} != sum_reg)
                begin
                    st_push    = 1'b1;
                    st_code    = psfp_pkg::STAT_CHECKSUM;
                    st_ft      = class_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next   = '0;
                    rd_ptr_next = psfp_pkg::HEAD_BYTES;
                    state_next  = ST_EMIT;
                end
            end
        end
        else if (state_reg == ST_EMIT && occ_next < 3'd2)
        begin
            // Issue one word read; the data joins the queue next cycle
            ram_rd_en      = 1'b1;
            pend_next      = 1'b1;
            pend_idx_next  = word_reg;
            pend_last_next = (word_reg == psfp_pkg::last_word(class_reg));
            word_next      = word_reg + 5'd1;
            rd_ptr_next    = rd_ptr_reg + 6'd2;
            if (word_reg == psfp_pkg::last_word(class_reg))
            begin
                state_next = ST_IDLE;
            end
        end
    end

    assign ram_wr_addr   = count_reg[AW-1:0];
    assign ram_wr_data   = rx_byte;
    assign ram_rd_addr_a = rd_ptr_reg[AW-1:0];
    assign ram_rd_addr_b = rd_ptr_b[AW-1:0];

    always_comb
    begin
        q_push.push = pend_reg || st_push;
        if (pend_reg)
        begin
            q_push.item.status     = psfp_pkg::STAT_OK;
            q_push.item.frame_type = class_reg;
            q_push.item.word_index = pend_idx_reg;
            q_push.item.word_value = {ram_rd_data_a, ram_rd_data_b};
            q_push.item.last       = pend_last_reg;
        end
        else
        begin
            q_push.item.status     = st_code;
            q_push.item.frame_type = st_ft;
            q_push.item.word_index = '0;
            q_push.item.word_value = '0;
            q_push.item.last       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            hdr_reg       <= '0;
            prev_byte_reg <= '0;
            sum_reg       <= '0;
            wait_reg      <= '0;
            class_reg     <= psfp_pkg::CLASS_24;
            limit_reg     <= psfp_pkg::WAIT_LIMIT_RESET;
            word_reg      <= '0;
            rd_ptr_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            hdr_reg       <= hdr_next;
            prev_byte_reg <= prev_byte_next;
            sum_reg       <= sum_next;
            wait_reg      <= wait_next;
            class_reg     <= class_next;
            limit_reg     <= limit_next;
            word_reg      <= word_next;
            rd_ptr_reg    <= rd_ptr_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            pend_last_reg <= pend_last_next;
        end
    end

    a_last_word_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && pend_last_reg) |-> (state_reg != ST_EMIT))
        else $error("emission continues past the last word");

    a_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == ST_BODY && count_reg < msg_bytes
                       && int'(count_reg) < BUFFER_BYTES))
        else $error("frame store write outside the frame");

    a_read_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> (int'(rd_ptr_b) < BUFFER_BYTES && rd_ptr_b < msg_bytes - 6'd2))
        else $error("word read beyond the data area");

endmodule

>>> rtl/core/particle_sensor_frame_parser.sv
// Channel | Dir | Payload                                            | Transaction
// --------+-----+----------------------------------------------------+----------------------
// cmd     | in  | command[1:0], rx_byte[7:0]                         | valid && ready
// cfg     | in  | wait_limit_ms[15:0]                                | valid && ready
// res     | out | status[2:0], frame_type[1:0], word_index[4:0],     | valid && ready
//         |     | word_value[15:0], last                             |
//
// Bytes, ticks and triggers are taken one per cycle while cmd is ready; cmd stalls in emission.
// The byte that completes a good frame starts emission: one data word per cycle from the
// dual-read frame store while the output queue has room, 9, 13 or 17 words, with cmd held off.
// Failures give one status result with no gap. cfg is always ready.
// Reset (rst_n low, async) idles the parser and loads a limit of 1000 ticks; the frame
// store has no reset. A stalled res holds two results in the output queue, then cmd stalls.
module particle_sensor_frame_parser #(
    parameter int BUFFER_BYTES = psfp_pkg::DEF_BUFFER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    psfp_chan_if.sink   cmd,
    psfp_chan_if.sink   cfg,
    psfp_chan_if.source res
);

    localparam int AW = $clog2(BUFFER_BYTES);

    // Frame store ports
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr_a;
    logic [AW-1:0] ram_rd_addr_b;
    logic [7:0]    ram_rd_data_a;
    logic [7:0]    ram_rd_data_b;

    // Controller to result queue
    psfp_pkg::res_push_t  q_push;
    psfp_pkg::outq_stat_t q_stat;

    // Body bytes land here; both bytes of a data word are read together on the two read ports
    psfp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_en     (ram_rd_en),
        .rd_addr_a (ram_rd_addr_a),
        .rd_addr_b (ram_rd_addr_b),
        .rd_data_a (ram_rd_data_a),
        .rd_data_b (ram_rd_data_b)
    );

    // Header check, checksum, timer and word sequencing
    psfp_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr_a (ram_rd_addr_a),
        .ram_rd_addr_b (ram_rd_addr_b),
        .ram_rd_data_a (ram_rd_data_a),
        .ram_rd_data_b (ram_rd_data_b),
        .q_stat        (q_stat),
        .q_push        (q_push)
    );

    // Two-entry result queue decouples res stalls from the controller
    psfp_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_stat (q_stat),
        .res    (res)
    );

endmodule

>>> bench/particle_sensor_frame_parser_tb.sv
`timescale 1ns / 1ps

module particle_sensor_frame_parser_tb;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int BUF_BYTES     = psfp_pkg::DEF_BUFFER_BYTES;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 25;    // random command transactions per limit setting
    localparam int SETTLE_CYCLES = 20;    // quiet time before a limit write
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
    localparam int WATCHDOG      = 2000;  // cycles with no transaction at all

    // Command value the block leaves unused
    localparam logic [1:0] CMD_NONE = 2'd3;
    // Frame type reported on status results that carry no size class
    localparam logic [1:0] NO_CLASS = 2'd0;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_HEAD,
        PARSE_BODY
    } parse_phase_t;

    // One row of the directed table: a command, and where the outcome is
    // obvious, the single status result it must produce.
    typedef struct packed {
        psfp_pkg::cmd_item_t item;
        logic                typed;
        psfp_pkg::res_item_t want;
    } dir_row_t;

    function automatic dir_row_t rw(logic [1:0] c, logic [7:0] b);
        dir_row_t r;
        r = '0;
        r.item.command = c;
        r.item.rx_byte = b;
        return r;
    endfunction

    function automatic dir_row_t rs(logic [1:0] c, logic [7:0] b, logic [2:0] st,
                                    logic [1:0] ft);
        dir_row_t r;
        r = rw(c, b);
        r.typed           = 1'b1;
        r.want.status     = st;
        r.want.frame_type = ft;
        r.want.last       = 1'b1;
        return r;
    endfunction

    // Directed table, run with a limit of one tick.
    localparam int DIR_ROWS = 27;
    dir_row_t directed [DIR_ROWS];

    logic clk = 1'b0;
    logic rst_n;

    psfp_chan_if #(.payload_t(psfp_pkg::cmd_item_t)) cmd_if ();
    psfp_chan_if #(.payload_t(logic [15:0]))         cfg_if ();
    psfp_chan_if #(.payload_t(psfp_pkg::res_item_t)) res_if ();

    particle_sensor_frame_parser #(
        .BUFFER_BYTES (BUF_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .cfg   (cfg_if),
        .res   (res_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Frame parser model: its own copy of the state and of the limit.
    // ------------------------------------------------------------------
    parse_phase_t parse_ph   = PARSE_IDLE;
    logic [7:0]   frame_mem [0:BUF_BYTES-1];
    logic [5:0]   byte_cnt   = '0;
    logic [15:0]  body_len   = '0;
    logic [15:0]  run_sum    = '0;
    logic [15:0]  tick_cnt   = '0;
    logic [1:0]   frame_cls  = NO_CLASS;
    logic [15:0]  wait_limit = psfp_pkg::WAIT_LIMIT_RESET;

    psfp_pkg::res_item_t step_words [$];      // results of the command just accepted
    psfp_pkg::res_item_t expected_words [$];  // results still owed by the block
    logic                step_live;

    // Bookkeeping
    int           cmd_count    = 0;
    int           live_items   = 0;
    int           res_count    = 0;
    int           good_frames  = 0;
    int           limit_writes = 0;
    int           mismatches   = 0;
    int           quiet_cycles = 0;
    logic [7:0]   codes_seen   = '0;

    // Stimulus controls shared with the receiver
    logic         full_rate = 1'b0;    // no gaps on either side
    logic         hold_req  = 1'b0;    // ask the receiver for one long hold-off

    task automatic load_directed();
        directed[0]  = rw(psfp_pkg::CMD_BYTE,    8'hFF);   // byte while idle: ignored
        directed[1]  = rw(psfp_pkg::CMD_TICK,    8'h00);   // tick while idle: ignored
        directed[2]  = rw(CMD_NONE,              8'hAA);   // unused command: ignored
        directed[3]  = rw(psfp_pkg::CMD_TRIGGER, 8'h55);
        // no byte before the limit
        directed[4]  = rs(psfp_pkg::CMD_TICK, 8'h00, psfp_pkg::STAT_TIMEOUT, NO_CLASS);
        directed[5]  = rw(psfp_pkg::CMD_TRIGGER, 8'h00);
        directed[6]  = rw(psfp_pkg::CMD_BYTE,    8'h42);
        // partial header
        directed[7]  = rs(psfp_pkg::CMD_TICK, 8'hFF, psfp_pkg::STAT_SHORT_HEAD, NO_CLASS);
        directed[8]  = rw(psfp_pkg::CMD_TRIGGER, 8'h00);
        directed[9]  = rw(psfp_pkg::CMD_BYTE,    8'h00);
        directed[10] = rw(psfp_pkg::CMD_BYTE,    8'hFF);
        directed[11] = rw(CMD_NONE,              8'h0F);   // unused command while busy
        directed[12] = rw(psfp_pkg::CMD_BYTE,    8'h00);
        directed[13] = rs(psfp_pkg::CMD_BYTE, 8'h14, psfp_pkg::STAT_BAD_START, NO_CLASS);
        directed[14] = rw(psfp_pkg::CMD_TRIGGER, 8'h00);
        directed[15] = rw(psfp_pkg::CMD_BYTE,    8'h42);
        directed[16] = rw(psfp_pkg::CMD_BYTE,    8'h4D);
        directed[17] = rw(psfp_pkg::CMD_BYTE,    8'hFF);
        // length field at maximum
        directed[18] = rs(psfp_pkg::CMD_BYTE, 8'hFF, psfp_pkg::STAT_UNKNOWN_LEN, NO_CLASS);
        directed[19] = rw(psfp_pkg::CMD_TRIGGER, 8'h00);
        directed[20] = rw(psfp_pkg::CMD_BYTE,    8'h42);
        directed[21] = rw(psfp_pkg::CMD_TRIGGER, 8'h00);   // restart drops the partial frame
        directed[22] = rw(psfp_pkg::CMD_BYTE,    8'h42);
        directed[23] = rw(psfp_pkg::CMD_BYTE,    8'h4D);
        directed[24] = rw(psfp_pkg::CMD_BYTE,    8'h00);
        directed[25] = rw(psfp_pkg::CMD_BYTE,    8'h14);   // good 24-byte header
        // no body byte yet
        directed[26] = rs(psfp_pkg::CMD_TICK, 8'h00, psfp_pkg::STAT_TIMEOUT,
                          psfp_pkg::CLASS_24);
    endtask

    function automatic void push_status(logic [2:0] st, logic [1:0] ft);
        psfp_pkg::res_item_t r;
        r            = '0;
        r.status     = st;
        r.frame_type = ft;
        r.last       = 1'b1;
        step_words.push_back(r);
        parse_ph = PARSE_IDLE;
    endfunction

    // Advance the model by one accepted command; collect results in step_words.
    task automatic parse_step(input psfp_pkg::cmd_item_t it);
        logic [16:0]         msg_len;
        logic [15:0]         chk;
        int                  nwords;
        int                  k;
        psfp_pkg::res_item_t w;
        step_words.delete();
        step_live = (it.command == psfp_pkg::CMD_TRIGGER) ||
                    ((it.command == psfp_pkg::CMD_BYTE || it.command == psfp_pkg::CMD_TICK) &&
                     parse_ph != PARSE_IDLE);
        msg_len = {1'b0, body_len} + 17'd4;
        if (it.command == psfp_pkg::CMD_TRIGGER)
        begin
            // Drop any frame in progress and restart counters and timer
            parse_ph  = PARSE_HEAD;
            byte_cnt  = '0;
            run_sum   = '0;
            tick_cnt  = '0;
            frame_cls = NO_CLASS;
            body_len  = '0;
        end
        else if (it.command == psfp_pkg::CMD_TICK && parse_ph != PARSE_IDLE)
        begin
            if (tick_cnt != 16'hFFFF)
                tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= wait_limit)
            begin
                if (parse_ph == PARSE_HEAD)
                    push_status(byte_cnt == '0 ? psfp_pkg::STAT_TIMEOUT
                                               : psfp_pkg::STAT_SHORT_HEAD, NO_CLASS);
                else
                    push_status(byte_cnt <= psfp_pkg::HEAD_BYTES ? psfp_pkg::STAT_TIMEOUT
                                                                 : psfp_pkg::STAT_SHORT_BODY,
                                frame_cls);
            end
        end
        else if (it.command == psfp_pkg::CMD_BYTE && parse_ph == PARSE_HEAD)
        begin
            if (byte_cnt < psfp_pkg::HEAD_BYTES)
            begin
                frame_mem[byte_cnt] = it.rx_byte;
                run_sum  = run_sum + 16'(it.rx_byte);
                byte_cnt = byte_cnt + 6'd1;
            end
            if (byte_cnt == psfp_pkg::HEAD_BYTES)
            begin
                if ({frame_mem[0], frame_mem[1]} != psfp_pkg::START_WORD)
                    push_status(psfp_pkg::STAT_BAD_START, NO_CLASS);
                else
                begin
                    body_len = {frame_mem[2], frame_mem[3]};
                    msg_len  = {1'b0, body_len} + 17'd4;
                    if (msg_len == 17'd24)
                        frame_cls = psfp_pkg::CLASS_24;
                    else if (msg_len == 17'd32)
                        frame_cls = psfp_pkg::CLASS_32;
                    else if (msg_len == 17'd40)
                        frame_cls = psfp_pkg::CLASS_40;
                    else
                        push_status(psfp_pkg::STAT_UNKNOWN_LEN, NO_CLASS);
                    // Known size: check the buffer fit
                    if (parse_ph == PARSE_HEAD)
                    begin
                        if (msg_len > 17'(BUF_BYTES))
                            push_status(psfp_pkg::STAT_TOO_LONG, NO_CLASS);
                        else
                            parse_ph = PARSE_BODY;
                    end
                end
            end
        end
        else if (it.command == psfp_pkg::CMD_BYTE && parse_ph == PARSE_BODY)
        begin
            if (17'(byte_cnt) < msg_len)
            begin
                frame_mem[byte_cnt] = it.rx_byte;
                // The checksum word itself stays out of the sum
                if (17'(byte_cnt) < msg_len - 17'd2)
                    run_sum = run_sum + 16'(it.rx_byte);
                byte_cnt = byte_cnt + 6'd1;
            end
            if (17'(byte_cnt) >= msg_len)
            begin
                chk = {frame_mem[msg_len - 17'd2], frame_mem[msg_len - 17'd1]};
                if (chk != run_sum)
                    push_status(psfp_pkg::STAT_CHECKSUM, frame_cls);
                else
                begin
                    nwords = (int'(msg_len) - 6) / 2;
                    for (k = 0; k < nwords; k++)
                    begin
                        w.status     = psfp_pkg::STAT_OK;
                        w.frame_type = frame_cls;
                        w.word_index = 5'(k);
                        w.word_value = {frame_mem[4 + 2 * k], frame_mem[5 + 2 * k]};
                        w.last       = (k == nwords - 1);
                        step_words.push_back(w);
                    end
                    parse_ph = PARSE_IDLE;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Command driver: draw a gap, offer the command, hold it until the
    // transaction, then predict. Valid stays high straight into the next
    // command when no gap follows.
    // ------------------------------------------------------------------
    task automatic send_item(input psfp_pkg::cmd_item_t it, input logic typed,
                             input psfp_pkg::res_item_t want);
        int gap;
        int i;
        gap = full_rate ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= it;
        do @(posedge clk); while (!cmd_if.ready);
        parse_step(it);
        cmd_count++;
        if (step_live)
            live_items++;
        if (typed)
            expected_words.push_back(want);
        else
        begin
            for (i = 0; i < step_words.size(); i++)
                expected_words.push_back(step_words[i]);
        end
    endtask

    task automatic send_cmd(input logic [1:0] c, input logic [7:0] b);
        psfp_pkg::cmd_item_t it;
        it.command = c;
        it.rx_byte = b;
        send_item(it, 1'b0, '0);
    endtask

    // Drop valid and hold until every owed result has been taken.
    task automatic wait_results();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
    endtask

    // Write the tick limit once the block has gone quiet.
    task automatic write_limit(input logic [15:0] lim);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= lim;
        do @(posedge clk); while (!cfg_if.ready);
        wait_limit = lim;
        limit_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Build a frame of the given class with a correct or broken checksum and
    // send the trigger and the first cut bytes (all of them when cut < 0).
    // A rare tick is mixed in so that small limits cut frames short.
    task automatic send_frame(input logic [1:0] cls, input logic corrupt, input int cut);
        logic [7:0]  fb [0:BUF_BYTES-1];
        logic [15:0] sum;
        int          flen;
        int          fill;
        int          i;
        int          nsend;
        flen  = (cls == psfp_pkg::CLASS_24) ? 24 : (cls == psfp_pkg::CLASS_32) ? 32 : 40;
        nsend = (cut < 0 || cut > flen) ? flen : cut;
        fill  = $urandom_range(0, 5);
        fb[0] = psfp_pkg::START_WORD[15:8];
        fb[1] = psfp_pkg::START_WORD[7:0];
        fb[2] = 8'((flen - 4) >> 8);
        fb[3] = 8'(flen - 4);
        for (i = 4; i < flen - 2; i++)
            fb[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
        sum = '0;
        for (i = 0; i < flen - 2; i++)
            sum = sum + 16'(fb[i]);
        fb[flen - 2] = sum[15:8];
        fb[flen - 1] = sum[7:0];
        if (corrupt)
        begin
            i = $urandom_range(0, 15);
            if (i < 8)
                fb[flen - 1][i] = ~fb[flen - 1][i];
            else
                fb[flen - 2][i - 8] = ~fb[flen - 2][i - 8];
        end
        send_cmd(psfp_pkg::CMD_TRIGGER, 8'($urandom));
        for (i = 0; i < nsend; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                send_cmd(psfp_pkg::CMD_TICK, 8'($urandom));
            send_cmd(psfp_pkg::CMD_BYTE, fb[i]);
        end
    endtask

    function automatic logic [1:0] pick_class();
        logic [1:0] cls;
        int         pick;
        pick = $urandom_range(0, 2);
        unique case (pick)
            0:       cls = psfp_pkg::CLASS_24;
            1:       cls = psfp_pkg::CLASS_32;
            default: cls = psfp_pkg::CLASS_40;
        endcase
        return cls;
    endfunction

    // One random sequence: half the time a well-formed frame, else a frame with
    // a broken checksum, a cut frame, a broken header or noise.
    task automatic random_sequence();
        logic [15:0] sw;
        logic [15:0] len;
        int          pick;
        int          n;
        int          i;
        pick = $urandom_range(0, 9);
        unique case (pick)
            0, 1, 2, 3, 4: send_frame(pick_class(), 1'b0, -1);
            5:             send_frame(pick_class(), 1'b1, -1);
            6, 7:
            begin
                // Cut the frame, then tick it out where the limit is small;
                // otherwise the next trigger drops it.
                send_frame(pick_class(), 1'b0, $urandom_range(0, 39));
                if (wait_limit <= 16'd64)
                begin
                    while (parse_ph != PARSE_IDLE)
                        send_cmd(psfp_pkg::CMD_TICK, 8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 3)) send_cmd(psfp_pkg::CMD_TICK, 8'($urandom));
                end
            end
            8:
            begin
                sw  = psfp_pkg::START_WORD;
                len = 16'($urandom_range(0, 40));
                if ($urandom_range(0, 1))
                    sw = sw ^ (16'd1 << $urandom_range(0, 15));
                else if ($urandom_range(0, 1))
                    len = 16'($urandom);
                send_cmd(psfp_pkg::CMD_TRIGGER, 8'($urandom));
                send_cmd(psfp_pkg::CMD_BYTE, sw[15:8]);
                send_cmd(psfp_pkg::CMD_BYTE, sw[7:0]);
                send_cmd(psfp_pkg::CMD_BYTE, len[15:8]);
                send_cmd(psfp_pkg::CMD_BYTE, len[7:0]);
            end
            default:
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    send_cmd(2'($urandom_range(0, 3)), 8'($urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result receiver: a random stall before each result, and one long
    // hold-off on request, counted here.
    // ------------------------------------------------------------------
    initial
    begin : res_sink
        int stall;
        res_if.ready = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = full_rate ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                @(negedge clk);
                res_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid && !hold_req);
        end
    end

    function automatic void match_field(string fname, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transaction with the oldest owed result.
    always @(posedge clk)
    begin : res_check
        psfp_pkg::res_item_t want;
        if (res_if.valid && res_if.ready)
        begin
            res_count++;
            if (expected_words.size() == 0)
            begin
                $display("%0t ns: expected no result, got status %0h type %0h index %0h",
                         $time, res_if.data.status, res_if.data.frame_type,
                         res_if.data.word_index);
                $display("%0t ns: expected no result, got value %0h last %0b",
                         $time, res_if.data.word_value, res_if.data.last);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                codes_seen[want.status] = 1'b1;
                if (want.status == psfp_pkg::STAT_OK && want.last)
                    good_frames++;
                match_field("status",     16'(want.status),     16'(res_if.data.status));
                match_field("frame_type", 16'(want.frame_type), 16'(res_if.data.frame_type));
                match_field("word_index", 16'(want.word_index), 16'(res_if.data.word_index));
                match_field("word_value", want.word_value,      res_if.data.word_value);
                match_field("last",       16'(want.last),       16'(res_if.data.last));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("%0t ns: no transaction for %0d cycles, %0d results still owed",
                     $time, quiet_cycles, expected_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        logic [15:0] limits [0:PHASES-1];
        int          ph;
        int          row;
        int          mark;
        int          fixed_items;
        int          target;

        rst_n        = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        fixed_items  = 0;
        target       = 0;
        load_directed();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Phases: reset limit (no write), zero limit, small, random small
        limits[0] = psfp_pkg::WAIT_LIMIT_RESET;
        limits[1] = 16'd0;
        limits[2] = 16'd3;
        limits[3] = 16'($urandom_range(2, 8));
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 1)
            begin
                // Directed table at a limit of one tick
                write_limit(16'd1);
                mark = cmd_count;
                for (row = 0; row < DIR_ROWS; row++)
                    send_item(directed[row].item, directed[row].typed, directed[row].want);
                fixed_items = fixed_items + (cmd_count - mark);
            end
            if (ph != 0)
                write_limit(limits[ph]);
            full_rate = (ph == 0);
            target    = target + PHASE_ITEMS;
            while (cmd_count - fixed_items < target)
                random_sequence();

            if (ph == 0)
            begin
                // Hold the receiver off while a long frame and more commands
                // keep coming, so the output queue fills and cmd stalls.
                mark     = cmd_count;
                hold_req = 1'b1;
                send_frame(psfp_pkg::CLASS_40, 1'b0, -1);
                send_cmd(psfp_pkg::CMD_TRIGGER, 8'h00);
                send_cmd(psfp_pkg::CMD_BYTE, psfp_pkg::START_WORD[15:8]);
                fixed_items = fixed_items + (cmd_count - mark);
                wait_results();
            end
            full_rate = 1'b0;
        end

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_words.size() != 0)
        begin
            $display("%0t ns: %0d results never arrived", $time, expected_words.size());
            mismatches++;
        end
        $display("Drove %0d commands (%0d live), checked %0d results over %0d good frames",
                 cmd_count, live_items, res_count, good_frames);
        $display("Limit writes %0d; status codes seen, bit per code from 7 down to 0: %b",
                 limit_writes, codes_seen);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/psfp_pkg.sv
rtl/core/psfp_chan_if.sv
rtl/core/psfp_ram.sv
rtl/core/psfp_outq.sv
rtl/core/psfp_ctrl.sv
rtl/core/particle_sensor_frame_parser.sv
bench/particle_sensor_frame_parser_tb.sv
